FILE: sv/fmc_pkg.sv
// fmc_pkg: shared types, codes and constants of the fuzzy membership classifier
// no dependencies; imported by every module of the block except fmc_fifo

package fmc_pkg;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_MEAN   = 2'd1;
  localparam logic [1:0] OP_DEV    = 2'd2;
  localparam logic [1:0] OP_ID     = 2'd3;

  localparam logic [2:0] REG_NUM_BANDS     = 3'd0;
  localparam logic [2:0] REG_NUM_CLASSES   = 3'd1;
  localparam logic [2:0] REG_Z_THRESHOLD   = 3'd2;
  localparam logic [2:0] REG_NODATA_ENABLE = 3'd3;
  localparam logic [2:0] REG_NODATA_VALUE  = 3'd4;

  localparam logic KIND_MEMB = 1'b0;
  localparam logic KIND_UNC  = 1'b1;

  localparam int DIV_NW = 64;
  localparam int DIV_DW = 32;
  localparam int SQ_RW  = 56;
  localparam int SQ_QW  = 28;
  localparam int SUM_W  = 48;

  localparam logic [15:0]      ONE_Q15 = 16'h8000;
  localparam logic [SUM_W-1:0] SAT48   = {SUM_W{1'b1}};

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  slot;
    logic [1:0]  band;
    logic [15:0] value;
    logic        first;
    logic        last;
    logic        nodata;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  slot;
    logic [15:0] id;
    logic [15:0] frac;
    logic        no_data;
    logic        last;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL,
    ST_DIV,
    ST_DIVW,
    ST_F_RD,
    ST_F_DIV,
    ST_F_DIVW,
    ST_F_SQW,
    ST_F_M,
    ST_F_MW,
    ST_N_RD,
    ST_N_CALC,
    ST_N_W,
    ST_N_PUSH,
    ST_U_MUL,
    ST_U_CALC,
    ST_U_W,
    ST_U_PUSH
  } st_t;

endpackage

FILE: sv/fmc_fifo.sv
// fmc_fifo: small register queue with full and empty flags
// no package dependencies; used for the command queue and the result queue

module fmc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = cnt_r == NW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

endmodule

FILE: sv/fmc_div.sv
// fmc_div: shared restoring divider, one quotient bit per cycle
// depends on fmc_pkg for the operand widths

module fmc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fmc_pkg::DIV_NW-1:0] num,
  input  logic [fmc_pkg::DIV_DW-1:0] den,
  output logic                      done,
  output logic [fmc_pkg::DIV_NW-1:0] quo
);
  import fmc_pkg::*;

  localparam int CNTW = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem_r, den_r;
  logic [DIV_NW-1:0] quo_r;
  logic [CNTW-1:0]   cnt_r;
  logic              busy_r, done_r;
  logic [DIV_DW:0]   trial;
  logic              qbit;
  logic [DIV_DW-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_NW-1]};
    qbit    = trial >= {1'b0, den_r};
    rem_nxt = qbit ? DIV_DW'(trial - {1'b0, den_r}) : DIV_DW'(trial);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_NW-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNTW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: sv/fmc_isqrt.sv
// fmc_isqrt: digit-by-digit integer square root, one root bit per cycle
// depends on fmc_pkg for the radicand and root widths

module fmc_isqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [fmc_pkg::SQ_RW-1:0] rad,
  output logic                     done,
  output logic [fmc_pkg::SQ_QW-1:0] root
);
  import fmc_pkg::*;

  localparam int CNTW = $clog2(SQ_QW + 1);

  logic [SQ_RW-1:0] rad_r;
  logic [SQ_QW+1:0] rem_r;
  logic [SQ_QW-1:0] root_r;
  logic [CNTW-1:0]  cnt_r;
  logic             busy_r, done_r;
  logic [SQ_QW+3:0] cur, trial;
  logic             take;

  always_comb begin
    cur   = {rem_r, rad_r[SQ_RW-1:SQ_RW-2]};
    trial = {2'b00, root_r, 2'b01};
    take  = cur >= trial;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SQ_RW-3:0], 2'b00};
      rem_r  <= take ? (SQ_QW+2)'(cur - trial) : (SQ_QW+2)'(cur);
      root_r <= {root_r[SQ_QW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNTW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(SQ_QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: sv/fmc_front.sv
// fmc_front: accepts items, drops the ones that have no effect, tags pixel start/end
// depends on fmc_pkg (cmd_t, op codes) and fmc_fifo (command queue)

module fmc_front #(
  parameter int MAX_CLASSES = 8,
  parameter int MAX_BANDS   = 4,
  parameter int NBW         = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_op,
  input  logic [2:0]          in_class_index,
  input  logic [1:0]          in_band_index,
  input  logic [15:0]         in_value,
  input  logic [NBW-1:0]      nb,
  input  logic                nodata_en,
  input  logic [15:0]         nodata_val,
  input  logic                cmd_pop,
  output logic                cmd_empty,
  output fmc_pkg::cmd_t       cmd
);
  import fmc_pkg::*;

  logic keep;
  logic q_full, q_push;
  cmd_t cmd_in;
  logic [$bits(cmd_t)-1:0] q_dout;

  always_comb begin
    case (in_op)
      OP_SAMPLE: keep = 6'(in_band_index) < 6'(nb);
      OP_ID:     keep = 32'(in_class_index) < MAX_CLASSES;
      default:   keep = (32'(in_class_index) < MAX_CLASSES) &&
                        (32'(in_band_index) < MAX_BANDS);
    endcase
  end

  always_comb begin
    cmd_in.op     = in_op;
    cmd_in.slot   = in_class_index;
    cmd_in.band   = in_band_index;
    cmd_in.value  = in_value;
    cmd_in.first  = in_band_index == 2'd0;
    cmd_in.last   = 6'(in_band_index) == (6'(nb) - 6'd1);
    cmd_in.nodata = nodata_en && (in_value == nodata_val);
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full && keep;

  fmc_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .dout  (q_dout),
    .empty (cmd_empty)
  );

  assign cmd = cmd_t'(q_dout);

endmodule

FILE: sv/fmc_back.sv
// fmc_back: class stores, distance accumulation, membership and uncertainty sequencer
// depends on fmc_pkg, fmc_div, fmc_isqrt and fmc_fifo (result queue)

module fmc_back #(
  parameter int MAX_CLASSES = 8,
  parameter int MAX_BANDS   = 4,
  parameter int NBW         = 3,
  parameter int CNW         = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [NBW-1:0]  nb,
  input  logic [CNW-1:0]  nc,
  input  logic [15:0]     thr,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  input  fmc_pkg::cmd_t   cmd,
  input  logic            out_pop,
  output logic            out_empty,
  output fmc_pkg::res_t   out_item
);
  import fmc_pkg::*;

  localparam int CW     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int BW     = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int AW     = CW + BW;
  localparam int MDEPTH = MAX_CLASSES * (2 ** BW);
  localparam int MSW    = 16 + $clog2(MAX_CLASSES);
  localparam int UAW    = MSW + CNW;

  st_t state_r, state_nxt;
  cmd_t cmd_r;
  logic [CW-1:0] c_r;
  logic c_last;

  logic [15:0]      means_mem [MDEPTH];
  logic [15:0]      devs_mem  [MDEPTH];
  logic [15:0]      ids_mem   [MAX_CLASSES];
  logic [SUM_W-1:0] sums_mem  [MAX_CLASSES];
  logic [15:0]      memb_mem  [MAX_CLASSES];
  logic [MAX_CLASSES-1:0] sum_vld_r;

  logic [15:0]      mean_q_r, dev_q_r, id_q_r, memb_q_r;
  logic [SUM_W-1:0] sum_q_r;
  logic             sum_v_r;

  logic [31:0]      ad2_r, dv2_r;
  logic [SUM_W-1:0] acc_r;
  logic [SQ_QW-1:0] z_r;
  logic [MSW-1:0]   msum_r;
  logic [15:0]      mmax_r;
  logic [UAW-1:0]   ua_r, ub_r;
  logic [15:0]      frac_r;
  logic             nodata_r;

  logic [AW-1:0]    rd_addr, ld_addr;
  logic [15:0]      ad, dev_eff;
  logic [SUM_W-1:0] term, snew;
  logic [SUM_W:0]   ssum;
  logic [15:0]      m_val, unc_q;
  logic             z_ge, norm_zero, unc_one;

  logic                div_start, div_done;
  logic [DIV_NW-1:0]   div_num, div_quo;
  logic [DIV_DW-1:0]   div_den;
  logic                sq_start, sq_done;
  logic [SQ_RW-1:0]    sq_rad;
  logic [SQ_QW-1:0]    sq_root;
  logic                out_push, out_full;
  res_t                out_res;
  logic                sum_we, memb_we, ld_mean_we, ld_dev_we, ld_id_we;
  logic [$bits(res_t)-1:0] out_dout;

  assign c_last    = CNW'(c_r) == (nc - CNW'(1));
  assign rd_addr   = {c_r, BW'(cmd_r.band)};
  assign ld_addr   = {CW'(cmd.slot), BW'(cmd.band)};
  assign z_ge      = z_r >= SQ_QW'(thr);
  assign norm_zero = nodata_r || (msum_r == '0);
  assign unc_one   = (nc == CNW'(1)) || (msum_r == '0);

  always_comb begin
    ad      = (cmd_r.value >= mean_q_r) ? cmd_r.value - mean_q_r : mean_q_r - cmd_r.value;
    dev_eff = (dev_q_r == '0) ? 16'd1 : dev_q_r;
    term    = (div_quo[DIV_NW-1:SUM_W] != '0) ? SAT48 : div_quo[SUM_W-1:0];
    ssum    = {1'b0, acc_r} + {1'b0, term};
    snew    = ssum[SUM_W] ? SAT48 : ssum[SUM_W-1:0];
    m_val   = (state_r == ST_F_M) ? 16'd0 : ONE_Q15 - div_quo[15:0];
    unc_q   = (div_quo > DIV_NW'(ONE_Q15)) ? ONE_Q15 : div_quo[15:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (!cmd_empty && cmd.op == OP_SAMPLE) state_nxt = ST_RD;
      ST_RD:     state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          if (!c_last) state_nxt = ST_RD;
          else state_nxt = cmd_r.last ? ST_F_RD : ST_IDLE;
        end
      end
      ST_F_RD:   state_nxt = ST_F_DIV;
      ST_F_DIV:  state_nxt = ST_F_DIVW;
      ST_F_DIVW: if (div_done) state_nxt = ST_F_SQW;
      ST_F_SQW:  if (sq_done) state_nxt = ST_F_M;
      ST_F_M: begin
        if (z_ge) state_nxt = c_last ? ST_N_RD : ST_F_RD;
        else state_nxt = ST_F_MW;
      end
      ST_F_MW:   if (div_done) state_nxt = c_last ? ST_N_RD : ST_F_RD;
      ST_N_RD:   state_nxt = ST_N_CALC;
      ST_N_CALC: state_nxt = norm_zero ? ST_N_PUSH : ST_N_W;
      ST_N_W:    if (div_done) state_nxt = ST_N_PUSH;
      ST_N_PUSH: if (!out_full) state_nxt = c_last ? ST_U_MUL : ST_N_RD;
      ST_U_MUL:  state_nxt = ST_U_CALC;
      ST_U_CALC: state_nxt = unc_one ? ST_U_PUSH : ST_U_W;
      ST_U_W:    if (div_done) state_nxt = ST_U_PUSH;
      ST_U_PUSH: if (!out_full) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop    = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sq_start   = 1'b0;
    sq_rad     = {div_quo[SUM_W-1:0], 8'b0};
    out_push   = 1'b0;
    sum_we     = 1'b0;
    memb_we    = 1'b0;
    ld_mean_we = 1'b0;
    ld_dev_we  = 1'b0;
    ld_id_we   = 1'b0;
    out_res.kind    = KIND_MEMB;
    out_res.slot    = 3'(c_r);
    out_res.id      = id_q_r;
    out_res.frac    = frac_r;
    out_res.no_data = nodata_r;
    out_res.last    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd_pop    = !cmd_empty;
        ld_mean_we = !cmd_empty && cmd.op == OP_MEAN;
        ld_dev_we  = !cmd_empty && cmd.op == OP_DEV;
        ld_id_we   = !cmd_empty && cmd.op == OP_ID;
      end
      ST_DIV: begin
        div_start = 1'b1;
        div_num   = DIV_NW'({ad2_r, 24'b0});
        div_den   = dv2_r;
      end
      ST_DIVW: sum_we = div_done;
      ST_F_DIV: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(sum_v_r ? sum_q_r : {SUM_W{1'b0}});
        div_den   = DIV_DW'(nb);
      end
      ST_F_DIVW: sq_start = div_done;
      ST_F_M: begin
        memb_we   = z_ge;
        div_start = !z_ge;
        div_num   = DIV_NW'({z_r, 15'b0});
        div_den   = DIV_DW'(thr);
      end
      ST_F_MW: memb_we = div_done;
      ST_N_CALC: begin
        div_start = !norm_zero;
        div_num   = DIV_NW'({memb_q_r, 15'b0});
        div_den   = DIV_DW'(msum_r);
      end
      ST_N_PUSH: out_push = !out_full;
      ST_U_CALC: begin
        div_start = !unc_one;
        div_num   = DIV_NW'({ua_r, 15'b0});
        div_den   = DIV_DW'(ub_r);
      end
      ST_U_PUSH: begin
        out_push     = !out_full;
        out_res.kind = KIND_UNC;
        out_res.slot = 3'd0;
        out_res.id   = 16'd0;
        out_res.frac = nodata_r ? 16'd0 : frac_r;
        out_res.last = 1'b1;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      c_r       <= '0;
      sum_vld_r <= '0;
      nodata_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd_pop && cmd.op == OP_SAMPLE) begin
        c_r <= '0;
        if (cmd.first) begin
          sum_vld_r <= '0;
          nodata_r  <= cmd.nodata;
        end
      end
      if (sum_we) begin
        sum_vld_r[c_r] <= 1'b1;
        c_r <= c_last ? '0 : c_r + CW'(1);
      end
      if (memb_we) begin
        c_r <= c_last ? '0 : c_r + CW'(1);
      end
      if (state_r == ST_N_PUSH && out_push && !c_last) begin
        c_r <= c_r + CW'(1);
      end
      if (state_r == ST_U_PUSH && out_push) begin
        sum_vld_r <= '0;
        nodata_r  <= 1'b0;
      end
    end
  end

  // class stores and working stores
  always_ff @(posedge clk) begin
    if (ld_mean_we) means_mem[ld_addr] <= cmd.value;
    if (ld_dev_we) devs_mem[ld_addr] <= (cmd.value == '0) ? 16'd1 : cmd.value;
    if (ld_id_we) ids_mem[CW'(cmd.slot)] <= cmd.value;
    if (sum_we) sums_mem[c_r] <= snew;
    if (memb_we) memb_mem[c_r] <= m_val;
    mean_q_r <= means_mem[rd_addr];
    dev_q_r  <= devs_mem[rd_addr];
    id_q_r   <= ids_mem[c_r];
    sum_q_r  <= sums_mem[c_r];
    sum_v_r  <= sum_vld_r[c_r];
    memb_q_r <= memb_mem[c_r];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cmd_r <= cmd;
    case (state_r)
      ST_MUL: begin
        ad2_r <= 32'(ad) * 32'(ad);
        dv2_r <= 32'(dev_eff) * 32'(dev_eff);
        acc_r <= sum_v_r ? sum_q_r : '0;
      end
      ST_DIVW: begin
        if (div_done && c_last) begin
          msum_r <= '0;
          mmax_r <= '0;
        end
      end
      ST_F_SQW: if (sq_done) z_r <= sq_root;
      ST_N_CALC: if (norm_zero) frac_r <= '0;
      ST_N_W: if (div_done) frac_r <= div_quo[15:0];
      ST_U_MUL: begin
        ua_r <= UAW'(nc) * UAW'(msum_r - MSW'(mmax_r));
        ub_r <= UAW'(nc - CNW'(1)) * UAW'(msum_r);
      end
      ST_U_CALC: if (unc_one) frac_r <= ONE_Q15;
      ST_U_W: if (div_done) frac_r <= unc_q;
      default: begin
        if (memb_we) begin
          msum_r <= msum_r + MSW'(m_val);
          if (m_val > mmax_r) mmax_r <= m_val;
        end
      end
    endcase
  end

  fmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  fmc_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (sq_rad),
    .done  (sq_done),
    .root  (sq_root)
  );

  fmc_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .din   (out_res),
    .full  (out_full),
    .pop   (out_pop),
    .dout  (out_dout),
    .empty (out_empty)
  );

  assign out_item = res_t'(out_dout);

`ifndef ASSERT_OFF
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full) else $error("result pushed into full queue");
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (out_res.frac <= ONE_Q15)) else $error("fraction above one");
  a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && nodata_r) |-> (out_res.frac == '0)) else $error("no-data fraction not zero");
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (CNW'(c_r) < nc)) else $error("class counter out of range");
  a_pixel_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_U_PUSH && out_push) |=> (sum_vld_r == '0 && !nodata_r))
    else $error("pixel state not cleared");
`endif

endmodule

FILE: sv/fuzzy_membership_classifier.sv
// Fuzzy membership classifier. Load items (op 1..3) write per-class band means,
// deviations and ids; the back end takes each one in its idle state. A band sample
// visits each class in use in turn, and each class uses the shared radix-2 divider.
// The last band of a pixel adds per class one division by the band count, a square
// root and one more division (skipped when z reaches the threshold), then one
// division per class for normalization and one for the uncertainty (skipped when C
// is 1 or all memberships are zero).
// A two-entry queue sits on each side, so items may be pushed while results wait.

module fuzzy_membership_classifier #(
  parameter int MAX_CLASSES = 8,
  parameter int MAX_BANDS   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_op,
  input  logic [2:0]  in_class_index,
  input  logic [1:0]  in_band_index,
  input  logic [15:0] in_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [2:0]  out_class_index_res,
  output logic [15:0] out_slot_id,
  output logic [15:0] out_fraction,
  output logic        out_no_data,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fmc_pkg::*;

  localparam int NBW = $clog2(MAX_BANDS + 1);
  localparam int CNW = $clog2(MAX_CLASSES + 1);

  logic [2:0]  num_bands_r;
  logic [3:0]  num_classes_r;
  logic [15:0] z_thr_r;
  logic        nd_en_r;
  logic [15:0] nd_val_r;
  logic        cfg_we;
  logic [NBW-1:0] nb;
  logic [CNW-1:0] nc;
  logic [15:0]    thr;
  logic        cmd_pop, cmd_empty;
  cmd_t        cmd;
  res_t        res;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bands_r   <= 3'd4;
      num_classes_r <= 4'd8;
      z_thr_r       <= 16'd8028;
      nd_en_r       <= 1'b0;
      nd_val_r      <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_paddr[4:2])
        REG_NUM_BANDS:     num_bands_r   <= cfg_pwdata[2:0];
        REG_NUM_CLASSES:   num_classes_r <= cfg_pwdata[3:0];
        REG_Z_THRESHOLD:   z_thr_r       <= cfg_pwdata[15:0];
        REG_NODATA_ENABLE: nd_en_r       <= cfg_pwdata[0];
        REG_NODATA_VALUE:  nd_val_r      <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_NUM_BANDS:     cfg_prdata = 32'(num_bands_r);
      REG_NUM_CLASSES:   cfg_prdata = 32'(num_classes_r);
      REG_Z_THRESHOLD:   cfg_prdata = 32'(z_thr_r);
      REG_NODATA_ENABLE: cfg_prdata = 32'(nd_en_r);
      REG_NODATA_VALUE:  cfg_prdata = 32'(nd_val_r);
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // effective counts and threshold
  always_comb begin
    if (num_bands_r == '0) nb = NBW'(1);
    else if (32'(num_bands_r) > MAX_BANDS) nb = NBW'(MAX_BANDS);
    else nb = NBW'(num_bands_r);
    if (num_classes_r == '0) nc = CNW'(1);
    else if (32'(num_classes_r) > MAX_CLASSES) nc = CNW'(MAX_CLASSES);
    else nc = CNW'(num_classes_r);
    thr = (z_thr_r == '0) ? 16'd1 : z_thr_r;
  end

  fmc_front #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_BANDS   (MAX_BANDS),
    .NBW         (NBW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_class_index (in_class_index),
    .in_band_index  (in_band_index),
    .in_value       (in_value),
    .nb             (nb),
    .nodata_en      (nd_en_r),
    .nodata_val     (nd_val_r),
    .cmd_pop        (cmd_pop),
    .cmd_empty      (cmd_empty),
    .cmd            (cmd)
  );

  fmc_back #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_BANDS   (MAX_BANDS),
    .NBW         (NBW),
    .CNW         (CNW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .nb        (nb),
    .nc        (nc),
    .thr       (thr),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (res)
  );

  assign out_kind            = res.kind;
  assign out_class_index_res = res.slot;
  assign out_slot_id         = res.id;
  assign out_fraction        = res.frac;
  assign out_no_data         = res.no_data;
  assign out_last            = res.last;

endmodule

FILE: tb/fuzzy_membership_classifier_test.sv
// fuzzy_membership_classifier_test: self-checking testbench of the fuzzy membership classifier
// a directed table then random pixels under several idle/stall mixes, checked by a local predictor
// depends on fmc_pkg and fuzzy_membership_classifier

module fuzzy_membership_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fmc_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int DRAIN_CYCLES   = 4000;
  localparam int HOLD_CYCLES    = 3000;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [15:0] data;
    logic [1:0]  op;
    logic [2:0]  ci;
    logic [1:0]  bi;
    bit          typed;
    logic [15:0] t_frac;
    bit          t_nd;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_op = '0;
  logic [2:0]  in_class_index = '0;
  logic [1:0]  in_band_index = '0;
  logic [15:0] in_value = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_kind;
  logic [2:0]  out_class_index_res;
  logic [15:0] out_slot_id;
  logic [15:0] out_fraction;
  logic        out_no_data;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  fuzzy_membership_classifier u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0]     band_mean [32];
  logic [15:0]     band_dev  [32];
  logic [15:0]     slot_id   [8];
  longint unsigned dist_sum  [8];
  bit              pix_nodata;
  logic [2:0]      r_bands = 3'd4;
  logic [3:0]      r_classes = 4'd8;
  logic [15:0]     r_zthr = 16'd8028;
  logic            r_nd_en = 1'b0;
  logic [15:0]     r_nd_val = 16'd0;

  res_t expected_results[$];
  int   errors = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_cnt = 0;
  int   quiet_cycles = 0;
  row_t tbl[$];

  function automatic int eff_bands();
    if (r_bands == 0) return 1;
    return (r_bands > 4) ? 4 : int'(r_bands);
  endfunction

  function automatic int eff_classes();
    if (r_classes == 0) return 1;
    return (r_classes > 8) ? 8 : int'(r_classes);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void queue_expected(res_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void add_row(row_t r);
    tbl.insert(tbl.size(), r);
  endfunction

  task automatic predict_item(logic [1:0] op, logic [2:0] ci, logic [1:0] bi,
                              logic [15:0] val, bit typed, logic [15:0] t_frac, bit t_nd);
    int nb, nc, idx;
    longint unsigned mean, dev, ad, term, thr, z12, msum, mmax, f, u, v64;
    longint unsigned memb[8];
    res_t r;
    nb = eff_bands();
    nc = eff_classes();
    msum = 0;
    mmax = 0;
    v64 = 64'(val);
    if (op == OP_ID) begin
      slot_id[ci] = val;
      return;
    end
    if (op == OP_MEAN) begin
      band_mean[ci*4 + bi] = val;
      return;
    end
    if (op == OP_DEV) begin
      band_dev[ci*4 + bi] = (val == 0) ? 16'd1 : val;
      return;
    end
    if (bi >= nb) return;
    if (bi == 0) begin
      foreach (dist_sum[c]) dist_sum[c] = 0;
      pix_nodata = r_nd_en && (val == r_nd_val);
    end
    for (int c = 0; c < nc; c++) begin
      idx = c*4 + bi;
      mean = 64'(band_mean[idx]);
      dev = (band_dev[idx] == 0) ? 64'd1 : 64'(band_dev[idx]);
      ad = (v64 >= mean) ? v64 - mean : mean - v64;
      term = ((ad * ad) << 24) / (dev * dev);
      if (term > SAT48) term = 64'(SAT48);
      dist_sum[c] += term;
      if (dist_sum[c] > SAT48) dist_sum[c] = 64'(SAT48);
    end
    if (bi != nb - 1) return;
    thr = (r_zthr == 0) ? 64'd1 : 64'(r_zthr);
    for (int c = 0; c < nc; c++) begin
      z12 = int_sqrt((dist_sum[c] / 64'(nb)) << 8);
      memb[c] = (z12 >= thr) ? 64'd0 : 64'd32768 - (z12 * 64'd32768) / thr;
      msum += memb[c];
      if (memb[c] > mmax) mmax = memb[c];
    end
    for (int c = 0; c < nc; c++) begin
      f = 0;
      if (!pix_nodata && msum != 0) f = (memb[c] * 64'd32768) / msum;
      r.kind = KIND_MEMB;
      r.slot = c[2:0];
      r.id = slot_id[c];
      r.frac = f[15:0];
      r.no_data = pix_nodata;
      r.last = 1'b0;
      if (typed) begin
        r.frac = t_frac;
        r.no_data = t_nd;
      end
      queue_expected(r);
    end
    u = 32768;
    if (nc > 1 && msum != 0) begin
      u = (64'd32768 * 64'(nc) * (msum - mmax)) / (64'(nc - 1) * msum);
      if (u > 32768) u = 32768;
    end
    if (pix_nodata) u = 0;
    r.kind = KIND_UNC;
    r.slot = '0;
    r.id = '0;
    r.frac = u[15:0];
    r.no_data = pix_nodata;
    r.last = 1'b1;
    if (typed) begin
      r.frac = t_frac;
      r.no_data = t_nd;
    end
    queue_expected(r);
    foreach (dist_sum[c]) dist_sum[c] = 0;
    pix_nodata = 1'b0;
  endtask

  task automatic send_item(logic [1:0] op, logic [2:0] ci, logic [1:0] bi, logic [15:0] val,
                           bit typed = 0, logic [15:0] t_frac = 0, bit t_nd = 0);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_op <= op;
    in_class_index <= ci;
    in_band_index <= bi;
    in_value <= val;
    do @(posedge clk); while (in_full);
    predict_item(op, ci, bi, val, typed, t_frac, t_nd);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    in_push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'd0, data};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_NUM_BANDS:     r_bands = data[2:0];
      REG_NUM_CLASSES:   r_classes = data[3:0];
      REG_Z_THRESHOLD:   r_zthr = data;
      REG_NODATA_ENABLE: r_nd_en = data[0];
      REG_NODATA_VALUE:  r_nd_val = data;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  function automatic row_t cfg_row(logic [2:0] idx, logic [15:0] data);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.reg_idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic row_t item_row(logic [1:0] op, logic [2:0] ci, logic [1:0] bi,
                                    logic [15:0] val, bit typed = 0, logic [15:0] t_frac = 0,
                                    bit t_nd = 0);
    row_t r;
    r = '{default: '0};
    r.op = op;
    r.ci = ci;
    r.bi = bi;
    r.data = val;
    r.typed = typed;
    r.t_frac = t_frac;
    r.t_nd = t_nd;
    return r;
  endfunction

  task automatic set_all(int nb, int nc, int z, int nde, int ndv);
    write_reg(REG_NUM_BANDS, 16'(nb));
    write_reg(REG_NUM_CLASSES, 16'(nc));
    write_reg(REG_Z_THRESHOLD, 16'(z));
    write_reg(REG_NODATA_ENABLE, 16'(nde));
    write_reg(REG_NODATA_VALUE, 16'(ndv));
  endtask

  task automatic random_phase(int n_items);
    int sent, pick, nb, c;
    logic [15:0] v;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      nb = eff_bands();
      if (pick < 10) begin
        send_item(2'($urandom_range(3, 1)), 3'($urandom_range(7)), 2'($urandom_range(3)),
                  16'($urandom()));
        sent++;
      end else if (pick < 18) begin
        send_item(OP_SAMPLE, 3'($urandom_range(7)), 2'($urandom_range(3)), 16'($urandom()));
        sent++;
      end else begin
        for (int b = 0; b < nb; b++) begin
          pick = $urandom_range(99);
          c = $urandom_range(eff_classes() - 1);
          if (pick < 55) v = band_mean[c*4 + b] + 16'($urandom_range(63)) - 16'd32;
          else if (pick < 65 && b == 0) v = r_nd_val;
          else v = 16'($urandom());
          send_item(OP_SAMPLE, 3'($urandom_range(7)), 2'(b), v);
          sent++;
        end
      end
    end
  endtask

  // receiver and checker
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_results.pop_front();
        if (out_kind !== e.kind) report_mismatch("kind", int'(out_kind), int'(e.kind));
        if (out_class_index_res !== e.slot)
          report_mismatch("class_index_res", int'(out_class_index_res), int'(e.slot));
        if (out_slot_id !== e.id) report_mismatch("slot_id", int'(out_slot_id), int'(e.id));
        if (out_fraction !== e.frac)
          report_mismatch("fraction", int'(out_fraction), int'(e.frac));
        if (out_no_data !== e.no_data)
          report_mismatch("no_data", int'(out_no_data), int'(e.no_data));
        if (out_last !== e.last) report_mismatch("last", int'(out_last), int'(e.last));
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    foreach (dist_sum[c]) dist_sum[c] = 0;
    pix_nodata = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every store entry before any sample reads it
    for (int c = 0; c < 8; c++) begin
      send_item(OP_ID, 3'(c), 2'd0, 16'($urandom()));
      for (int b = 0; b < 4; b++) begin
        send_item(OP_MEAN, 3'(c), 2'(b), 16'($urandom()));
        send_item(OP_DEV, 3'(c), 2'(b), (b == 3) ? 16'd0 : 16'($urandom_range(4095)));
      end
    end

    add_row(cfg_row(REG_NUM_BANDS, 1));
    add_row(cfg_row(REG_NUM_CLASSES, 1));
    add_row(item_row(OP_MEAN, 0, 0, 1000));
    add_row(item_row(OP_DEV, 0, 0, 16));
    add_row(item_row(OP_ID, 0, 0, 16'hFFFF));
    add_row(item_row(OP_SAMPLE, 0, 0, 1000, 1, ONE_Q15, 0));
    add_row(item_row(OP_SAMPLE, 7, 0, 0));
    add_row(item_row(OP_SAMPLE, 0, 0, 16'hFFFF));
    add_row(item_row(OP_DEV, 0, 0, 0));
    add_row(item_row(OP_SAMPLE, 0, 0, 1001));
    add_row(item_row(OP_SAMPLE, 0, 0, 1000, 1, ONE_Q15, 0));
    add_row(cfg_row(REG_NUM_BANDS, 4));
    add_row(cfg_row(REG_NUM_CLASSES, 8));
    add_row(cfg_row(REG_NODATA_ENABLE, 1));
    add_row(cfg_row(REG_NODATA_VALUE, 16'hFFFF));
    add_row(item_row(OP_SAMPLE, 0, 0, 16'hFFFF));
    add_row(item_row(OP_SAMPLE, 0, 1, 0));
    add_row(item_row(OP_SAMPLE, 0, 2, 7));
    add_row(item_row(OP_SAMPLE, 0, 3, 16'hFFFF, 1, 16'd0, 1));
    add_row(item_row(OP_SAMPLE, 0, 2, 5));
    add_row(item_row(OP_SAMPLE, 0, 2, 5));
    add_row(item_row(OP_SAMPLE, 0, 3, 9));
    add_row(cfg_row(REG_NUM_BANDS, 2));
    add_row(item_row(OP_SAMPLE, 0, 3, 3));
    add_row(item_row(OP_SAMPLE, 0, 0, 1));
    add_row(item_row(OP_SAMPLE, 0, 1, 2));
    add_row(cfg_row(REG_NUM_BANDS, 0));
    add_row(cfg_row(REG_NUM_CLASSES, 0));
    add_row(cfg_row(REG_Z_THRESHOLD, 0));
    add_row(item_row(OP_SAMPLE, 0, 0, 4));
    add_row(cfg_row(REG_NUM_BANDS, 7));
    add_row(cfg_row(REG_NUM_CLASSES, 15));
    add_row(cfg_row(REG_Z_THRESHOLD, 16'hFFFF));
    add_row(cfg_row(REG_NODATA_ENABLE, 0));
    add_row(item_row(OP_SAMPLE, 0, 0, 16'h8000));
    add_row(item_row(OP_SAMPLE, 0, 1, 16'h7FFF));
    add_row(item_row(OP_SAMPLE, 0, 2, 16'h5555));
    add_row(item_row(OP_SAMPLE, 0, 3, 16'hAAAA));
    foreach (tbl[i]) begin
      if (tbl[i].is_cfg) write_reg(tbl[i].reg_idx, tbl[i].data);
      else send_item(tbl[i].op, tbl[i].ci, tbl[i].bi, tbl[i].data,
                     tbl[i].typed, tbl[i].t_frac, tbl[i].t_nd);
    end

    // no idling, with a long receiver hold-off so the input backs up
    set_all(4, 8, 65535, 1, $urandom());
    idle_pct = 0;
    stall_pct = 0;
    hold_req++;
    random_phase(16);

    set_all(1, 1, 1, 0, 0);
    idle_pct = 77;
    stall_pct = 0;
    random_phase(16);

    set_all(3, $urandom_range(8, 1), $urandom_range(65535, 1), 1, $urandom());
    idle_pct = 0;
    stall_pct = 77;
    random_phase(16);

    set_all(2, 8, 8028, 0, 16'hFFFF);
    idle_pct = 36;
    stall_pct = 36;
    random_phase(16);

    in_push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
